/* sv/trrc_pkg.sv */
// shared constants and types for the rounded rectangle outline coverage block
`default_nettype none

package trrc_pkg;

   localparam int COORD_BITS     = 12;
   localparam int MAX_LINE_WIDTH = 16;
   localparam int MAX_RADIUS     = 8;
   localparam int MIN_RADIUS     = 2;
   localparam int RADIUS_DIVISOR = 4;

   localparam int RADIUS_SHIFT   = $clog2(RADIUS_DIVISOR);
   localparam int DIM_BITS       = COORD_BITS - 1;
   localparam int THICK_BITS     = 5;
   localparam int CW             = COORD_BITS + 2;
   localparam int RB             = $clog2(MAX_RADIUS + 1);
   localparam int SQ_BITS        = 2 * RB;
   localparam int D2_BITS        = SQ_BITS + 1;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = COORD_BITS;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_LEFT      = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_TOP       = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_WIDTH     = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RECT_HEIGHT    = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LINE_THICKNESS = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROUND_CORNERS  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_INK            = 3'd6;

   typedef struct packed {
      logic                 en;
      logic                 arc_en;
      logic signed [CW-1:0] ix;
      logic signed [CW-1:0] iy;
      logic signed [CW-1:0] rx;
      logic signed [CW-1:0] by;
      logic signed [CW-1:0] cxl;
      logic signed [CW-1:0] cxr;
      logic signed [CW-1:0] cyt;
      logic signed [CW-1:0] cyb;
      logic [RB-1:0]        r;
      logic [SQ_BITS-1:0]   lo;
      logic [SQ_BITS-1:0]   hi;
   } layer_geom_type;

   typedef layer_geom_type [MAX_LINE_WIDTH-1:0] geom_array_type;

endpackage

`default_nettype wire

/* sv/trrc_setup.sv */
// configuration registers and per-layer outline geometry
`default_nettype none

module trrc_setup (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_en,
   input  wire logic [trrc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [trrc_pkg::CSR_DATA_BITS-1:0]   csr_write_data,
   output trrc_pkg::geom_array_type                  geom,
   output logic                                      cfg_ink
);

   logic signed [trrc_pkg::COORD_BITS-1:0] rect_left_ff;
   logic signed [trrc_pkg::COORD_BITS-1:0] rect_top_ff;
   logic [trrc_pkg::DIM_BITS-1:0]          rect_width_ff;
   logic [trrc_pkg::DIM_BITS-1:0]          rect_height_ff;
   logic [trrc_pkg::THICK_BITS-1:0]        thick_ff;
   logic                                   round_ff;
   logic                                   ink_ff;

   trrc_pkg::geom_array_type geom_in;
   trrc_pkg::geom_array_type geom_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rect_left_ff   <= '0;
         rect_top_ff    <= '0;
         rect_width_ff  <= '0;
         rect_height_ff <= '0;
         thick_ff       <= trrc_pkg::THICK_BITS'(1);
         round_ff       <= 1'b0;
         ink_ff         <= 1'b1;
      end else if (csr_write_en) begin
         unique case (csr_index)
            trrc_pkg::CSR_RECT_LEFT: begin
               rect_left_ff <= csr_write_data[trrc_pkg::COORD_BITS-1:0];
            end
            trrc_pkg::CSR_RECT_TOP: begin
               rect_top_ff <= csr_write_data[trrc_pkg::COORD_BITS-1:0];
            end
            trrc_pkg::CSR_RECT_WIDTH: begin
               rect_width_ff <= csr_write_data[trrc_pkg::DIM_BITS-1:0];
            end
            trrc_pkg::CSR_RECT_HEIGHT: begin
               rect_height_ff <= csr_write_data[trrc_pkg::DIM_BITS-1:0];
            end
            trrc_pkg::CSR_LINE_THICKNESS: begin
               thick_ff <= csr_write_data[trrc_pkg::THICK_BITS-1:0];
            end
            trrc_pkg::CSR_ROUND_CORNERS: begin
               round_ff <= csr_write_data[0];
            end
            trrc_pkg::CSR_INK: begin
               ink_ff <= csr_write_data[0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin : geom_calc
      logic [trrc_pkg::DIM_BITS-1:0]          min_dim;
      logic [trrc_pkg::DIM_BITS-1:0]          quarter;
      logic [trrc_pkg::RB-1:0]                base;
      logic [trrc_pkg::RB-1:0]                r;
      logic [trrc_pkg::RB-1:0]                rm1;
      logic signed [trrc_pkg::CW-1:0]         x0;
      logic signed [trrc_pkg::CW-1:0]         y0;
      logic signed [trrc_pkg::CW-1:0]         wd;
      logic signed [trrc_pkg::CW-1:0]         ht;
      logic signed [trrc_pkg::CW-1:0]         iw;
      logic signed [trrc_pkg::CW-1:0]         ih;
      logic signed [trrc_pkg::CW-1:0]         hw;
      logic signed [trrc_pkg::CW-1:0]         hh;
      logic signed [trrc_pkg::CW-1:0]         rw;
      logic signed [trrc_pkg::CW-1:0]         ix;
      logic signed [trrc_pkg::CW-1:0]         iy;
      logic signed [trrc_pkg::CW-1:0]         rx;
      logic signed [trrc_pkg::CW-1:0]         by;
      min_dim = (rect_width_ff < rect_height_ff) ? rect_width_ff : rect_height_ff;
      quarter = min_dim >> trrc_pkg::RADIUS_SHIFT;
      if (!round_ff) begin
         base = '0;
      end else if (quarter > trrc_pkg::DIM_BITS'(trrc_pkg::MAX_RADIUS)) begin
         base = trrc_pkg::RB'(trrc_pkg::MAX_RADIUS);
      end else if (quarter < trrc_pkg::DIM_BITS'(trrc_pkg::MIN_RADIUS)) begin
         base = trrc_pkg::RB'(trrc_pkg::MIN_RADIUS);
      end else begin
         base = quarter[trrc_pkg::RB-1:0];
      end
      x0 = trrc_pkg::CW'(rect_left_ff);
      y0 = trrc_pkg::CW'(rect_top_ff);
      wd = trrc_pkg::CW'(rect_width_ff);
      ht = trrc_pkg::CW'(rect_height_ff);
      for (int l = 0; l < trrc_pkg::MAX_LINE_WIDTH; l++) begin
         iw = wd - trrc_pkg::CW'(2 * l);
         ih = ht - trrc_pkg::CW'(2 * l);
         hw = iw >>> 1;
         hh = ih >>> 1;
         // radius shrinks per layer, then fits inside half the inset size
         if (int'(base) > l) begin
            r = base - trrc_pkg::RB'(l);
         end else begin
            r = '0;
         end
         rw = trrc_pkg::CW'(r);
         if (rw > hw) begin
            r = hw[trrc_pkg::RB-1:0];
         end
         rw = trrc_pkg::CW'(r);
         if (rw > hh) begin
            r = hh[trrc_pkg::RB-1:0];
         end
         rw = trrc_pkg::CW'(r);
         rm1 = r - trrc_pkg::RB'(1);
         ix = x0 + trrc_pkg::CW'(l);
         iy = y0 + trrc_pkg::CW'(l);
         rx = x0 + wd - trrc_pkg::CW'(l + 1);
         by = y0 + ht - trrc_pkg::CW'(l + 1);
         geom_in[l].en     = (int'(thick_ff) > l) && (iw > 0) && (ih > 0);
         geom_in[l].arc_en = geom_in[l].en && (r != '0);
         geom_in[l].ix     = ix;
         geom_in[l].iy     = iy;
         geom_in[l].rx     = rx;
         geom_in[l].by     = by;
         geom_in[l].cxl    = ix + rw;
         geom_in[l].cxr    = rx - rw;
         geom_in[l].cyt    = iy + rw;
         geom_in[l].cyb    = by - rw;
         geom_in[l].r      = r;
         geom_in[l].lo     = trrc_pkg::SQ_BITS'(rm1) * trrc_pkg::SQ_BITS'(rm1);
         geom_in[l].hi     = trrc_pkg::SQ_BITS'(r) * trrc_pkg::SQ_BITS'(r);
      end
   end

   always_ff @(posedge clock) begin
      geom_ff <= geom_in;
   end

   assign geom    = geom_ff;
   assign cfg_ink = ink_ff;

endmodule

`default_nettype wire

/* sv/trrc_layer.sv */
// three-stage coverage test of one outline layer
`default_nettype none

module trrc_layer (
   input  wire logic                                  clock,
   input  wire logic                                  advance,
   input  wire trrc_pkg::layer_geom_type              geom,
   input  wire logic signed [trrc_pkg::COORD_BITS-1:0] pixel_x,
   input  wire logic signed [trrc_pkg::COORD_BITS-1:0] pixel_y,
   output logic                                       layer_hit
);

   localparam int SIDE_LEFT   = 0;
   localparam int SIDE_RIGHT  = 1;
   localparam int SIDE_TOP    = 2;
   localparam int SIDE_BOTTOM = 3;

   function automatic logic in_window(input logic signed [trrc_pkg::CW-1:0] d,
                                      input logic signed [trrc_pkg::CW-1:0] lim);
      return !d[trrc_pkg::CW-1] && (d <= lim);
   endfunction

   function automatic logic on_ring(input logic [trrc_pkg::SQ_BITS-1:0] sa,
                                    input logic [trrc_pkg::SQ_BITS-1:0] sb,
                                    input logic [trrc_pkg::SQ_BITS-1:0] lo,
                                    input logic [trrc_pkg::SQ_BITS-1:0] hi);
      logic [trrc_pkg::D2_BITS-1:0] d2;
      d2 = trrc_pkg::D2_BITS'(sa) + trrc_pkg::D2_BITS'(sb);
      return (d2 >= trrc_pkg::D2_BITS'(lo)) && (d2 <= trrc_pkg::D2_BITS'(hi));
   endfunction

   logic                                  a_edge_in,  a_edge_ff;
   logic [3:0]                            a_ok_in,    a_ok_ff;
   logic [3:0][trrc_pkg::RB-1:0]          a_mag_in,   a_mag_ff;
   logic                                  b_edge_in,  b_edge_ff;
   logic [3:0]                            b_ok_in,    b_ok_ff;
   logic [3:0][trrc_pkg::SQ_BITS-1:0]     b_sq_in,    b_sq_ff;
   logic                                  c_hit_in,   c_hit_ff;

   // stage a: edge runs and offsets from the arc centres
   always_comb begin : stage_a
      logic signed [trrc_pkg::CW-1:0] px;
      logic signed [trrc_pkg::CW-1:0] py;
      logic signed [trrc_pkg::CW-1:0] rw;
      logic signed [trrc_pkg::CW-1:0] dl;
      logic signed [trrc_pkg::CW-1:0] dr;
      logic signed [trrc_pkg::CW-1:0] dt;
      logic signed [trrc_pkg::CW-1:0] db;
      logic                           row_hit;
      logic                           col_hit;
      px = trrc_pkg::CW'(pixel_x);
      py = trrc_pkg::CW'(pixel_y);
      rw = trrc_pkg::CW'(geom.r);
      row_hit = ((py == geom.iy) || (py == geom.by)) && (px >= geom.cxl) && (px <= geom.cxr);
      col_hit = ((px == geom.ix) || (px == geom.rx)) && (py >= geom.cyt) && (py <= geom.cyb);
      a_edge_in = geom.en && (row_hit || col_hit);
      dl = geom.cxl - px;
      dr = px - geom.cxr;
      dt = geom.cyt - py;
      db = py - geom.cyb;
      a_ok_in[SIDE_LEFT]    = in_window(dl, rw);
      a_ok_in[SIDE_RIGHT]   = in_window(dr, rw);
      a_ok_in[SIDE_TOP]     = in_window(dt, rw);
      a_ok_in[SIDE_BOTTOM]  = in_window(db, rw);
      a_mag_in[SIDE_LEFT]   = dl[trrc_pkg::RB-1:0];
      a_mag_in[SIDE_RIGHT]  = dr[trrc_pkg::RB-1:0];
      a_mag_in[SIDE_TOP]    = dt[trrc_pkg::RB-1:0];
      a_mag_in[SIDE_BOTTOM] = db[trrc_pkg::RB-1:0];
   end

   // stage b: squared offsets
   always_comb begin
      b_edge_in = a_edge_ff;
      b_ok_in   = a_ok_ff;
      for (int i = 0; i < 4; i++) begin
         b_sq_in[i] = trrc_pkg::SQ_BITS'(a_mag_ff[i]) * trrc_pkg::SQ_BITS'(a_mag_ff[i]);
      end
   end

   // stage c: quarter arc rings
   always_comb begin : stage_c
      logic tl;
      logic tr;
      logic br;
      logic bl;
      tl = b_ok_ff[SIDE_LEFT] && b_ok_ff[SIDE_TOP] &&
           on_ring(b_sq_ff[SIDE_LEFT], b_sq_ff[SIDE_TOP], geom.lo, geom.hi);
      tr = b_ok_ff[SIDE_RIGHT] && b_ok_ff[SIDE_TOP] &&
           on_ring(b_sq_ff[SIDE_RIGHT], b_sq_ff[SIDE_TOP], geom.lo, geom.hi);
      br = b_ok_ff[SIDE_RIGHT] && b_ok_ff[SIDE_BOTTOM] &&
           on_ring(b_sq_ff[SIDE_RIGHT], b_sq_ff[SIDE_BOTTOM], geom.lo, geom.hi);
      bl = b_ok_ff[SIDE_LEFT] && b_ok_ff[SIDE_BOTTOM] &&
           on_ring(b_sq_ff[SIDE_LEFT], b_sq_ff[SIDE_BOTTOM], geom.lo, geom.hi);
      c_hit_in = b_edge_ff || (geom.arc_en && (tl || tr || br || bl));
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_edge_ff <= a_edge_in;
         a_ok_ff   <= a_ok_in;
         a_mag_ff  <= a_mag_in;
         b_edge_ff <= b_edge_in;
         b_ok_ff   <= b_ok_in;
         b_sq_ff   <= b_sq_in;
         c_hit_ff  <= c_hit_in;
      end
   end

   assign layer_hit = c_hit_ff;

endmodule

`default_nettype wire

/* sv/thick_rounded_rect_coverage.sv */
// top level: request pipeline, layer array and result register
`default_nettype none

// Pixel coverage for a thick, optionally rounded rectangle outline. One request
// (a pixel coordinate) is taken every clock while req_stall is low, and passes
// through an input register, three stages in each of the sixteen parallel layer
// testers (edge compares and arc offsets, squaring, ring compare) and the result
// register that merges the layers. Sustained rate is one pixel per clock while
// the result side does not stall. A stall on the result side freezes the whole
// pipeline and is passed back as req_stall in the same cycle. Register writes
// feed a registered geometry stage, so they count from the next clock edge on;
// a request may follow a write in the very next cycle.
module thick_rounded_rect_coverage (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [trrc_pkg::COORD_BITS-1:0] req_pixel_x,
   input  wire logic signed [trrc_pkg::COORD_BITS-1:0] req_pixel_y,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic                                        rsp_hit,
   output logic                                        rsp_pixel_value,
   input  wire logic                                   csr_write_en,
   input  wire logic [trrc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire logic [trrc_pkg::CSR_DATA_BITS-1:0]     csr_write_data
);

   trrc_pkg::geom_array_type                geom;
   logic                                    cfg_ink;
   logic [trrc_pkg::MAX_LINE_WIDTH-1:0]     layer_hit;
   logic                                    advance;
   logic                                    accept;

   logic                                    s0_valid_in,  s0_valid_ff;
   logic signed [trrc_pkg::COORD_BITS-1:0]  s0_x_ff;
   logic signed [trrc_pkg::COORD_BITS-1:0]  s0_y_ff;
   logic                                    a_valid_in,   a_valid_ff;
   logic                                    b_valid_in,   b_valid_ff;
   logic                                    c_valid_in,   c_valid_ff;
   logic                                    rsp_valid_in, rsp_valid_ff;
   logic                                    rsp_hit_in,   rsp_hit_ff;
   logic                                    rsp_value_in, rsp_value_ff;

   trrc_setup u_setup (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .geom           (geom),
      .cfg_ink        (cfg_ink)
   );

   for (genvar l = 0; l < trrc_pkg::MAX_LINE_WIDTH; l++) begin : g_layer
      trrc_layer u_layer (
         .clock     (clock),
         .advance   (advance),
         .geom      (geom[l]),
         .pixel_x   (s0_x_ff),
         .pixel_y   (s0_y_ff),
         .layer_hit (layer_hit[l])
      );
   end

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !advance;
   assign accept    = req_valid && advance;

   always_comb begin
      s0_valid_in  = req_valid;
      a_valid_in   = s0_valid_ff;
      b_valid_in   = a_valid_ff;
      c_valid_in   = b_valid_ff;
      rsp_valid_in = c_valid_ff;
      rsp_hit_in   = |layer_hit;
      rsp_value_in = rsp_hit_in & cfg_ink;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= s0_valid_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_x_ff      <= req_pixel_x;
         s0_y_ff      <= req_pixel_y;
         rsp_hit_ff   <= rsp_hit_in;
         rsp_value_ff <= rsp_value_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_pixel_value = rsp_value_ff;

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      accept |=> s0_valid_ff)
      else $error("accepted request did not enter the pipeline");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable({s0_valid_ff, a_valid_ff, b_valid_ff, c_valid_ff}))
      else $error("pipeline moved while stalled");

   a_last_stage_drains: assert property (@(posedge clock) disable iff (reset)
      advance && c_valid_ff |=> rsp_valid_ff)
      else $error("last stage result lost");

   a_empty_outline: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !geom[0].en |-> !rsp_hit_ff)
      else $error("hit reported with no outline layer");

endmodule

`default_nettype wire
